// ===== hw/rtl/catmull_rom_segment_sampler_unit_defines.svh =====
// assertion macros for the segment sampler
`ifndef CATMULL_ROM_SEGMENT_SAMPLER_UNIT_DEFINES_SVH
`define CATMULL_ROM_SEGMENT_SAMPLER_UNIT_DEFINES_SVH

// expr must never be true outside reset
`define CRS_ASSERT_NEVER(lbl, clk, rst, expr) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("crs check failed");

// ante in a cycle implies cons in the next cycle
`define CRS_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("crs check failed");

// ante implies cons in the same cycle
`define CRS_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("crs check failed");

`endif

// ===== hw/rtl/crs_pkg.sv =====
// shared constants and codes of the segment sampler
package crs_pkg;
   localparam int STEPS       = 20;
   localparam int FRAC_BITS   = 16;
   localparam int RATIO_BITS  = 22;
   localparam int KW          = 6;
   localparam int TW          = 40;
   localparam logic [63:0] RATIO_LIMIT = 64'd1 << 29;

   localparam logic [1:0] MODE_UNIFORM     = 2'd0;
   localparam logic [1:0] MODE_CENTRIPETAL = 2'd1;
endpackage

// ===== hw/rtl/catmull_rom_segment_sampler_unit.sv =====
// catmull-rom segment sampler: sequencer around shared multiplier, root and divider
// a point that only fills the window is taken in S_IDLE without leaving it
// a point that closes a window has its three knot gaps worked out (squared terms, then
// one root, or two in centripetal mode; none in uniform mode), then per sample 5 divisions
// and 18 blends unless the segment is degenerate; one item is worked on at a time
// reset: no points held, knot_mode centripetal, no item pending
`include "catmull_rom_segment_sampler_unit_defines.svh"
module catmull_rom_segment_sampler_unit import crs_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,   // x, y, z
   input  logic         req_tuser,   // start_new
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // px, py, pz
   output logic         rsp_tlast,   // last_sample
   output logic         rsp_tuser,   // degenerate
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_data     // knot_mode
);
   localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_SQ_ACC = 4'd2, S_ROOT_GO = 4'd3,
      S_ROOT1 = 4'd4, S_ROOT2 = 4'd5, S_KNOT = 4'd6, S_SAMPLE = 4'd7, S_DIV_GO = 4'd8,
      S_DIV_WAIT = 4'd9, S_BL_MUL = 4'd10, S_BL_ACC = 4'd11, S_OUT = 4'd12;

   logic [3:0]              state_ff, state_in;
   logic [1:0]              mode_ff, mode_in, held_ff, held_in;
   logic [2:0][2:0][31:0]   win_ff, win_in;
   logic [2:0][31:0]        pt_ff, pt_in;
   logic [3:0][2:0][31:0]   pall;
   logic [1:0]              gi_ff, gi_in, c_ff, c_in;
   logic [63:0]             sum_ff, sum_in;
   logic [2:0][31:0]        g_ff, g_in;
   logic [TW-1:0]           t1_ff, t1_in, t2_ff, t2_in, t3_ff, t3_in, off_ff, off_in;
   logic                    degen_ff, degen_in, rneg_ff, rneg_in;
   logic [KW-1:0]           k_ff, k_in;
   logic [2:0]              ri_ff, ri_in, bi_ff, bi_in;
   logic [4:0][30:0]        r_ff, r_in;
   logic [31:0]             a1_ff, a1_in, a2_ff, a2_in, a3_ff, a3_in;
   logic [31:0]             b1_ff, b1_in, b2_ff, b2_in;
   logic [2:0][31:0]        out_ff, out_in;

   logic signed [33:0] mul_a, mul_b;
   logic signed [67:0] mul_prod;
   logic               sq_start, sq_busy, dv_start, dv_busy;
   logic [63:0]        sq_op, dv_dividend, dv_quo;
   logic [31:0]        sq_root;
   logic [TW-1:0]      dv_den;

   logic [31:0]        pa, pb, bp, bq;
   logic signed [32:0] dsub, bdiff;
   logic [32:0]        dmag;
   logic [30:0]        msq, br, rq;
   logic [1:0]         held_eff;
   logic [1:0]         gi_next;
   logic [TW-1:0]      tcur;
   logic signed [TW:0] num;
   logic [TW-1:0]      nmag;
   logic [63:0]        qsat;
   logic signed [63:0] prod64;
   logic [63:0]        pmag, rnd;
   logic [41:0]        dd;
   logic signed [43:0] bsum;
   logic [31:0]        bres;

   crs_mul u_mul (.clock(clock), .a(mul_a), .b(mul_b), .prod(mul_prod));
   crs_sqrt u_sqrt (.clock(clock), .reset(reset), .start(sq_start), .op(sq_op),
      .busy(sq_busy), .root(sq_root));
   crs_div u_div (.clock(clock), .reset(reset), .start(dv_start), .dividend(dv_dividend),
      .divisor(dv_den), .busy(dv_busy), .quotient(dv_quo));

   assign pall       = {pt_ff, win_ff};
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = {out_ff[2], out_ff[1], out_ff[0]};
   assign rsp_tlast  = (k_ff == KW'(STEPS));
   assign rsp_tuser  = degen_ff;
   assign csr_ready  = 1'b1;

   // chord term of one coordinate
   assign gi_next = gi_ff + 2'd1;
   assign pa   = pall[gi_ff][c_ff];
   assign pb   = pall[gi_next][c_ff];
   assign dsub = $signed({pb[31], pb}) - $signed({pa[31], pa});
   assign dmag = dsub[32] ? 33'(-dsub) : 33'(dsub);
   assign msq  = dmag[32:2];

   // blend operand selection
   always_comb begin
      bp = pall[0][c_ff];
      bq = pall[1][c_ff];
      br = r_ff[0];
      case (bi_ff)
         3'd0: begin bp = pall[0][c_ff]; bq = pall[1][c_ff]; br = r_ff[0]; end
         3'd1: begin bp = pall[1][c_ff]; bq = pall[2][c_ff]; br = r_ff[1]; end
         3'd2: begin bp = pall[2][c_ff]; bq = pall[3][c_ff]; br = r_ff[2]; end
         3'd3: begin bp = a1_ff; bq = a2_ff; br = r_ff[3]; end
         3'd4: begin bp = a2_ff; bq = a3_ff; br = r_ff[4]; end
         3'd5: begin bp = b1_ff; bq = b2_ff; br = r_ff[1]; end
         default: begin bp = b1_ff; bq = b2_ff; br = r_ff[1]; end
      endcase
   end
   assign bdiff = $signed({bq[31], bq}) - $signed({bp[31], bp});

   always_comb begin
      if (state_ff == S_SQ) begin
         mul_a = $signed({3'b000, msq});
         mul_b = $signed({3'b000, msq});
      end else begin
         mul_a = 34'(bdiff);
         mul_b = 34'($signed(br));
      end
   end

   // rounded blend result, saturated to 32 bits
   assign prod64 = mul_prod[63:0];
   assign pmag   = prod64[63] ? 64'(-prod64) : 64'(prod64);
   assign rnd    = pmag + (64'd1 << (RATIO_BITS - 1));
   assign dd     = rnd[63:RATIO_BITS];
   assign bsum   = prod64[63] ? (44'($signed(bp)) - $signed({2'b00, dd}))
                              : (44'($signed(bp)) + $signed({2'b00, dd}));
   always_comb begin
      if (bsum > 44'sd2147483647) begin
         bres = 32'h7fff_ffff;
      end else if (bsum < -44'sd2147483648) begin
         bres = 32'h8000_0000;
      end else begin
         bres = bsum[31:0];
      end
   end

   // ratio numerator and denominator
   assign tcur = t1_ff + off_ff;
   always_comb begin
      num    = $signed({1'b0, tcur});
      dv_den = t1_ff;
      case (ri_ff)
         3'd0: begin num = $signed({1'b0, tcur});   dv_den = t1_ff; end
         3'd1: begin num = $signed({1'b0, off_ff}); dv_den = t2_ff - t1_ff; end
         3'd2: begin num = $signed({1'b0, tcur}) - $signed({1'b0, t2_ff});
                     dv_den = t3_ff - t2_ff; end
         3'd3: begin num = $signed({1'b0, tcur});   dv_den = t2_ff; end
         3'd4: begin num = $signed({1'b0, off_ff}); dv_den = t3_ff - t1_ff; end
         default: begin num = $signed({1'b0, off_ff}); dv_den = t3_ff - t1_ff; end
      endcase
   end
   assign nmag        = num[TW] ? TW'(-num) : TW'(num);
   assign dv_dividend = 64'({nmag, {RATIO_BITS{1'b0}}});
   assign dv_start    = (state_ff == S_DIV_GO);
   assign qsat        = (dv_quo > RATIO_LIMIT) ? RATIO_LIMIT : dv_quo;
   assign rq          = rneg_ff ? 31'(-qsat[30:0]) : qsat[30:0];

   assign held_eff = req_tuser ? 2'd0 : held_ff;

   always_comb begin
      state_in = state_ff;
      mode_in  = mode_ff;
      held_in  = held_ff;
      win_in   = win_ff;
      pt_in    = pt_ff;
      gi_in    = gi_ff;
      c_in     = c_ff;
      sum_in   = sum_ff;
      g_in     = g_ff;
      t1_in    = t1_ff;
      t2_in    = t2_ff;
      t3_in    = t3_ff;
      off_in   = off_ff;
      degen_in = degen_ff;
      rneg_in  = rneg_ff;
      k_in     = k_ff;
      ri_in    = ri_ff;
      bi_in    = bi_ff;
      r_in     = r_ff;
      a1_in    = a1_ff;
      a2_in    = a2_ff;
      a3_in    = a3_ff;
      b1_in    = b1_ff;
      b2_in    = b2_ff;
      out_in   = out_ff;
      sq_start = 1'b0;
      sq_op    = sum_ff;
      if (csr_valid) begin
         mode_in = csr_data;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               if (held_eff != 2'd3) begin
                  win_in[held_eff] = {req_tdata[95:64], req_tdata[63:32], req_tdata[31:0]};
                  held_in = held_eff + 2'd1;
               end else begin
                  held_in = 2'd3;
                  pt_in   = {req_tdata[95:64], req_tdata[63:32], req_tdata[31:0]};
                  gi_in   = 2'd0;
                  c_in    = 2'd0;
                  sum_in  = 64'd0;
                  if (mode_ff == MODE_UNIFORM) begin
                     g_in     = {3{32'd1 << FRAC_BITS}};
                     state_in = S_KNOT;
                  end else begin
                     state_in = S_SQ;
                  end
               end
            end
         end
         S_SQ: begin
            state_in = S_SQ_ACC;
         end
         S_SQ_ACC: begin
            sum_in = sum_ff + mul_prod[63:0];
            if (c_ff == 2'd2) begin
               state_in = S_ROOT_GO;
            end else begin
               c_in     = c_ff + 2'd1;
               state_in = S_SQ;
            end
         end
         S_ROOT_GO: begin
            sq_start = 1'b1;
            sq_op    = sum_ff;
            state_in = S_ROOT1;
         end
         S_ROOT1: begin
            if (!sq_busy) begin
               if (mode_ff == MODE_CENTRIPETAL) begin
                  sq_start = 1'b1;
                  sq_op    = {sq_root, 32'd0};
                  state_in = S_ROOT2;
               end else begin
                  g_in[gi_ff] = sq_root;
                  gi_in    = gi_next;
                  c_in     = 2'd0;
                  sum_in   = 64'd0;
                  state_in = (gi_ff == 2'd2) ? S_KNOT : S_SQ;
               end
            end
         end
         S_ROOT2: begin
            if (!sq_busy) begin
               g_in[gi_ff] = sq_root;
               gi_in    = gi_next;
               c_in     = 2'd0;
               sum_in   = 64'd0;
               state_in = (gi_ff == 2'd2) ? S_KNOT : S_SQ;
            end
         end
         S_KNOT: begin
            t1_in    = TW'(g_ff[0]) * TW'(STEPS);
            t2_in    = TW'(g_ff[0]) * TW'(STEPS) + TW'(g_ff[1]) * TW'(STEPS);
            t3_in    = TW'(g_ff[0]) * TW'(STEPS) + TW'(g_ff[1]) * TW'(STEPS)
                     + TW'(g_ff[2]) * TW'(STEPS);
            degen_in = (g_ff[0] == 32'd0) || (g_ff[1] == 32'd0) || (g_ff[2] == 32'd0);
            off_in   = '0;
            k_in     = '0;
            state_in = S_SAMPLE;
         end
         S_SAMPLE: begin
            if (degen_ff) begin
               out_in   = pall[1];
               state_in = S_OUT;
            end else begin
               ri_in    = 3'd0;
               state_in = S_DIV_GO;
            end
         end
         S_DIV_GO: begin
            rneg_in  = num[TW];
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (!dv_busy) begin
               r_in[ri_ff] = rq;
               if (ri_ff == 3'd4) begin
                  bi_in    = 3'd0;
                  c_in     = 2'd0;
                  state_in = S_BL_MUL;
               end else begin
                  ri_in    = ri_ff + 3'd1;
                  state_in = S_DIV_GO;
               end
            end
         end
         S_BL_MUL: begin
            state_in = S_BL_ACC;
         end
         S_BL_ACC: begin
            state_in = S_BL_MUL;
            bi_in    = bi_ff + 3'd1;
            case (bi_ff)
               3'd0: a1_in = bres;
               3'd1: a2_in = bres;
               3'd2: a3_in = bres;
               3'd3: b1_in = bres;
               3'd4: b2_in = bres;
               default: begin
                  out_in[c_ff] = bres;
                  bi_in = 3'd0;
                  if (c_ff == 2'd2) begin
                     state_in = S_OUT;
                  end else begin
                     c_in = c_ff + 2'd1;
                  end
               end
            endcase
         end
         S_OUT: begin
            if (rsp_tready) begin
               if (k_ff == KW'(STEPS)) begin
                  win_in   = {pt_ff, win_ff[2], win_ff[1]};
                  state_in = S_IDLE;
               end else begin
                  k_in     = k_ff + KW'(1);
                  off_in   = off_ff + TW'(g_ff[1]);
                  state_in = S_SAMPLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= MODE_CENTRIPETAL;
         held_ff  <= 2'd0;
         win_ff   <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         held_ff  <= held_in;
         win_ff   <= win_in;
         k_ff     <= k_in;
      end
      pt_ff    <= pt_in;
      gi_ff    <= gi_in;
      c_ff     <= c_in;
      sum_ff   <= sum_in;
      g_ff     <= g_in;
      t1_ff    <= t1_in;
      t2_ff    <= t2_in;
      t3_ff    <= t3_in;
      off_ff   <= off_in;
      degen_ff <= degen_in;
      rneg_ff  <= rneg_in;
      ri_ff    <= ri_in;
      bi_ff    <= bi_in;
      r_ff     <= r_in;
      a1_ff    <= a1_in;
      a2_ff    <= a2_in;
      a3_ff    <= a3_in;
      b1_ff    <= b1_in;
      b2_ff    <= b2_in;
      out_ff   <= out_in;
   end

   `CRS_ASSERT_NEVER(a_no_overlap, clock, reset, req_tready && rsp_tvalid)
   `CRS_ASSERT_NEXT(a_last_to_idle, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast,
      req_tready)
   `CRS_ASSERT_IMPLY(a_degen_mode, clock, reset, rsp_tvalid && rsp_tuser,
      mode_ff != MODE_UNIFORM)
endmodule

// ===== hw/rtl/crs_mul.sv =====
// shared signed multiplier with registered product
module crs_mul import crs_pkg::*; (
   input  logic               clock,
   input  logic signed [33:0] a,
   input  logic signed [33:0] b,
   output logic signed [67:0] prod
);
   logic signed [67:0] prod_ff;
   logic signed [67:0] prod_in;

   assign prod_in = a * b;
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end
endmodule

// ===== hw/rtl/crs_sqrt.sv =====
// bit-serial integer square root, two radicand bits per cycle
module crs_sqrt import crs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] op,
   output logic        busy,
   output logic [31:0] root
);
   logic [63:0] v_ff, v_in, res_ff, res_in, bit_ff, bit_in;
   logic [63:0] trial;

   assign busy  = (bit_ff != 64'd0);
   assign root  = res_ff[31:0];
   assign trial = res_ff + bit_ff;

   always_comb begin
      v_in   = v_ff;
      res_in = res_ff;
      bit_in = bit_ff;
      if (start) begin
         v_in   = op;
         res_in = 64'd0;
         bit_in = 64'd1 << 62;
      end else if (busy) begin
         if (v_ff >= trial) begin
            v_in   = v_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_ff <= 64'd0;
      end else begin
         bit_ff <= bit_in;
      end
      v_ff   <= v_in;
      res_ff <= res_in;
   end
endmodule

// ===== hw/rtl/crs_div.sv =====
// restoring divider, one quotient bit per cycle
module crs_div import crs_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [63:0]   dividend,
   input  logic [TW-1:0] divisor,
   output logic          busy,
   output logic [63:0]   quotient
);
   logic [TW-1:0] rem_ff, rem_in, den_ff, den_in;
   logic [63:0]   quo_ff, quo_in;
   logic [6:0]    cnt_ff, cnt_in;
   logic [TW:0]   r2;

   assign busy     = (cnt_ff != 7'd0);
   assign quotient = quo_ff;
   assign r2       = {rem_ff, quo_ff[63]};

   always_comb begin
      rem_in = rem_ff;
      den_in = den_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (start) begin
         rem_in = '0;
         den_in = divisor;
         quo_in = dividend;
         cnt_in = 7'd64;
      end else if (busy) begin
         if (r2 >= {1'b0, den_ff}) begin
            rem_in = TW'(r2 - {1'b0, den_ff});
            quo_in = {quo_ff[62:0], 1'b1};
         end else begin
            rem_in = r2[TW-1:0];
            quo_in = {quo_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 7'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end
endmodule

// ===== test/tb_catmull_rom_segment_sampler_unit.sv =====
// testbench for the catmull-rom segment sampler: random and directed points, sample checking
`timescale 1ns / 100ps
module tb_catmull_rom_segment_sampler_unit;
   import crs_pkg::*;

   typedef struct {
      logic [31:0] x, y, z;
      logic        start_new;
   } point_type;

   typedef struct {
      logic [31:0] px, py, pz;
      logic        last_sample;
      logic        degenerate;
   } sample_type;

   localparam logic [1:0] MODE_CHORDAL = 2'd2;
   localparam logic [1:0] MODE_SPARE   = 2'd3;
   localparam int HOLD_CYCLES = 30000;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [95:0]  req_tdata;   // x, y, z
   logic         req_tuser;   // start_new
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [95:0]  rsp_tdata;   // px, py, pz
   logic         rsp_tlast;   // last_sample
   logic         rsp_tuser;   // degenerate
   logic         csr_valid;
   logic         csr_ready;
   logic [1:0]   csr_data;    // knot_mode

   point_type  point_queue[$];
   sample_type sample_queue[$];
   int      send_idle, recv_stall;
   int      mismatches;
   logic    hold_on, hold_go;

   // spline window as the block should hold it
   logic [31:0] win_x[3], win_y[3], win_z[3];
   int          win_count;
   logic [1:0]  model_mode;

   catmull_rom_segment_sampler_unit uut (.*);

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
         if (v >= root + bitv) begin
            v -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic longint unsigned knot_spacing(longint a[3], longint b[3]);
      longint unsigned sum, m, chord;
      longint d;
      sum = 0;
      if (model_mode == MODE_UNIFORM) return 64'd1 << FRAC_BITS;
      for (int c = 0; c < 3; c++) begin
         d = b[c] - a[c];
         m = (d < 0) ? -d : d;
         m >>= 2;
         sum += m * m;
      end
      chord = int_sqrt(sum);
      if (model_mode == MODE_CENTRIPETAL) return int_sqrt(chord << 32);
      return chord;
   endfunction

   function automatic longint blend_ratio(longint num, longint den);
      longint unsigned mag, q;
      mag = (num < 0) ? -num : num;
      q = (mag << RATIO_BITS) / den;
      if (q > RATIO_LIMIT) q = RATIO_LIMIT;
      return (num < 0) ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint lerp_sat(longint p, longint q, longint r);
      longint prod, res;
      longint unsigned mag, d;
      prod = (q - p) * r;
      mag = (prod < 0) ? -prod : prod;
      d = (mag + (64'd1 << (RATIO_BITS - 1))) >> RATIO_BITS;
      res = p + ((prod < 0) ? -longint'(d) : longint'(d));
      if (res > 64'sd2147483647) res = 64'sd2147483647;
      if (res < -64'sd2147483648) res = -64'sd2147483648;
      return res;
   endfunction

   // works out the samples one accepted point causes
   task automatic sample_segment(point_type pt);
      longint p[4][3];
      longint unsigned g0, g1, g2;
      longint t1, t2, t3, t, ra1, ra2, ra3, rb1, rb2, a1, a2, a3, b1, b2;
      logic degen;
      sample_type s;
      logic [31:0] v[3];
      if (pt.start_new) win_count = 0;
      if (win_count < 3) begin
         win_x[win_count] = pt.x;
         win_y[win_count] = pt.y;
         win_z[win_count] = pt.z;
         win_count++;
         return;
      end
      for (int i = 0; i < 3; i++) begin
         p[i][0] = signed'(win_x[i]);
         p[i][1] = signed'(win_y[i]);
         p[i][2] = signed'(win_z[i]);
      end
      p[3][0] = signed'(pt.x);
      p[3][1] = signed'(pt.y);
      p[3][2] = signed'(pt.z);
      g0 = knot_spacing(p[0], p[1]);
      g1 = knot_spacing(p[1], p[2]);
      g2 = knot_spacing(p[2], p[3]);
      degen = (g0 == 0) || (g1 == 0) || (g2 == 0);
      t1 = g0 * STEPS;
      t2 = t1 + g1 * STEPS;
      t3 = t2 + g2 * STEPS;
      for (int k = 0; k <= STEPS; k++) begin
         for (int c = 0; c < 3; c++) begin
            if (degen) begin
               v[c] = p[1][c][31:0];
            end else begin
               t = t1 + longint'(g1) * k;
               ra1 = blend_ratio(t, t1);
               ra2 = blend_ratio(t - t1, t2 - t1);
               ra3 = blend_ratio(t - t2, t3 - t2);
               rb1 = blend_ratio(t, t2);
               rb2 = blend_ratio(t - t1, t3 - t1);
               a1 = lerp_sat(p[0][c], p[1][c], ra1);
               a2 = lerp_sat(p[1][c], p[2][c], ra2);
               a3 = lerp_sat(p[2][c], p[3][c], ra3);
               b1 = lerp_sat(a1, a2, rb1);
               b2 = lerp_sat(a2, a3, rb2);
               v[c] = 32'(lerp_sat(b1, b2, ra2));
            end
         end
         s.px = v[0];
         s.py = v[1];
         s.pz = v[2];
         s.last_sample = (k == STEPS);
         s.degenerate = degen;
         sample_queue.insert(sample_queue.size(), s);
      end
      for (int i = 0; i < 2; i++) begin
         win_x[i] = win_x[i + 1];
         win_y[i] = win_y[i + 1];
         win_z[i] = win_z[i + 1];
      end
      win_x[2] = pt.x;
      win_y[2] = pt.y;
      win_z[2] = pt.z;
   endtask

   // point driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
         req_tdata <= '0;
         req_tuser <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            sample_segment(point_queue[0]);
            void'(point_queue.pop_front());
         end
         if (req_tvalid && !req_tready) begin
            req_tvalid <= 1;
         end else if (point_queue.size() > 0 && $urandom_range(99) >= send_idle) begin
            req_tvalid <= 1;
            req_tdata <= {point_queue[0].z, point_queue[0].y, point_queue[0].x};
            req_tuser <= point_queue[0].start_new;
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // sample monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else begin
         rsp_tready <= !hold_on && ($urandom_range(99) >= recv_stall);
         if (rsp_tvalid && rsp_tready) begin
            if (sample_queue.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected sample %h", rsp_tdata);
            end else begin
               if (rsp_tdata !== {sample_queue[0].pz, sample_queue[0].py, sample_queue[0].px}
                   || rsp_tlast !== sample_queue[0].last_sample
                   || rsp_tuser !== sample_queue[0].degenerate) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("sample mismatch: exp %h last %b degen %b, got %h last %b degen %b",
                              {sample_queue[0].pz, sample_queue[0].py, sample_queue[0].px},
                              sample_queue[0].last_sample, sample_queue[0].degenerate,
                              rsp_tdata, rsp_tlast, rsp_tuser);
               end
               void'(sample_queue.pop_front());
            end
         end
      end
   end

   // long receiver hold-off so the block backs up into its input
   initial begin
      hold_on = 0;
      wait (hold_go);
      @(posedge clock);
      hold_on <= 1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_on <= 0;
   end

   initial begin
      #240_000_000;
      $display("catmull_rom_segment_sampler_unit verification failed");
      $finish;
   end

   task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic s);
      point_type pt;
      pt.x = x;
      pt.y = y;
      pt.z = z;
      pt.start_new = s;
      point_queue.insert(point_queue.size(), pt);
   endtask

   task automatic wait_idle();
      wait (point_queue.size() == 0 && sample_queue.size() == 0);
      repeat (50) @(posedge clock);
   endtask

   task automatic write_mode(logic [1:0] m);
      @(posedge clock);
      csr_valid <= 1;
      csr_data <= m;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      model_mode = m;
   endtask

   // mostly clean curves, some wide-range noise, repeats and restarts
   task automatic add_random(int n);
      logic [31:0] x, y, z;
      x = 0; y = 0; z = 0;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(9))
            0: begin x = $urandom; y = $urandom; z = $urandom; end
            1: ;
            default: begin
               x = x + 32'($signed($urandom_range(65535 * 8)) - 65535 * 4);
               y = y + 32'($signed($urandom_range(65535 * 8)) - 65535 * 4);
               z = z + 32'($signed($urandom_range(65535 * 8)) - 65535 * 4);
            end
         endcase
         add_point(x, y, z, $urandom_range(19) == 0);
      end
   endtask

   initial begin
      reset = 1;
      csr_valid = 0;
      csr_data = 0;
      hold_go = 0;
      send_idle = 0;
      recv_stall = 0;
      mismatches = 0;
      win_count = 0;
      model_mode = MODE_CENTRIPETAL;
      repeat (12) @(posedge clock);
      reset <= 0;

      // extremes, repeated point, restart and wild extrapolation
      add_point(32'h0, 32'h0, 32'h0, 1);
      add_point(32'h7FFFFFFF, 32'h0, 32'h80000000, 0);
      add_point(32'h80000000, 32'h7FFFFFFF, 32'h0, 0);
      add_point(32'h00001000, 32'h00002000, 32'h00003000, 0);
      add_point(32'h00001000, 32'h00002000, 32'h00003000, 0);
      add_point(32'hFFFFFFFF, 32'h80000000, 32'h7FFFFFFF, 0);
      add_point(32'h7FFF0000, 32'h7FFF0000, 32'h7FFF0000, 1);
      add_point(32'h0, 32'h0, 32'h0, 0);
      add_point(32'h00000040, 32'h0, 32'h0, 0);
      add_point(32'h80010000, 32'h80010000, 32'h80010000, 0);
      add_point(32'h00010000, 32'hFFFF0000, 32'h00020000, 0);
      add_point(32'h00030000, 32'h00010000, 32'hFFFE0000, 1);
      add_point(32'h00040000, 32'h00020000, 32'h00000000, 0);
      add_point(32'h00060000, 32'h00050000, 32'h00010000, 0);
      add_point(32'h00080000, 32'h00030000, 32'h00030000, 0);
      add_point(32'h00090000, 32'h00090000, 32'h00090000, 0);
      wait_idle();

      write_mode(MODE_UNIFORM);
      add_random(78);
      wait_idle();

      write_mode(MODE_CHORDAL);
      send_idle = 78;
      add_random(78);
      wait_idle();

      write_mode(MODE_SPARE);
      send_idle = 0;
      recv_stall = 78;
      add_random(78);
      wait_idle();

      write_mode(MODE_CENTRIPETAL);
      send_idle = 15;
      recv_stall = 15;
      add_random(78);
      wait_idle();

      write_mode(MODE_CHORDAL);
      send_idle = 0;
      recv_stall = 0;
      hold_go = 1;
      add_random(78);
      wait_idle();
      repeat (100) @(posedge clock);

      if (mismatches == 0) begin
         $display("catmull_rom_segment_sampler_unit verification clean");
      end else begin
         $display("catmull_rom_segment_sampler_unit verification failed");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/crs_pkg.sv
hw/rtl/crs_mul.sv
hw/rtl/crs_sqrt.sv
hw/rtl/crs_div.sv
hw/rtl/catmull_rom_segment_sampler_unit.sv
test/tb_catmull_rom_segment_sampler_unit.sv
